// File: design/rkv_pkg.sv
package rkv_pkg;

    localparam int ENTRIES    = 64;
    localparam int DATA_BITS  = 32;
    localparam int IDX_BITS   = $clog2(ENTRIES);
    localparam int CNT_BITS   = IDX_BITS + 1;
    localparam int KEY_BITS   = 64;
    localparam int COUNT_BITS = 16;
    localparam int OUT_BITS   = 32;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        MODE_ADD    = 2'd0,
        MODE_READ   = 2'd1,
        MODE_COUNT  = 2'd2,
        MODE_REMOVE = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL     = 2'd2,
        ST_DUP      = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        POL_REJECT    = 2'd0,
        POL_OVERWRITE = 2'd1,
        POL_INCREMENT = 2'd2
    } policy_t;

    localparam logic [1:0] REG_POLICY = 2'd0;
    localparam logic [1:0] REG_TEXT   = 2'd1;
    localparam logic [1:0] REG_BYTES  = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    // Token that travels down the cell row alongside the request.
    typedef struct packed {
        logic                 hit;
        logic                 free;
        logic [IDX_BITS-1:0]  hit_idx;
        logic [IDX_BITS-1:0]  free_idx;
        logic [DATA_BITS-1:0] hit_data;
        logic [COUNT_BITS-1:0] hit_count;
    } scan_t;

    // Write-back command broadcast from the controller to every cell.
    typedef struct packed {
        logic                  en;
        logic [IDX_BITS-1:0]   idx;
        logic                  set_valid;
        logic                  clr_valid;
        logic                  wr_key;
        logic                  wr_data;
        logic                  wr_count;
        logic [KEY_BITS-1:0]   key;
        logic [DATA_BITS-1:0]  data;
        logic [COUNT_BITS-1:0] count;
    } wb_t;

    function automatic logic keys_match(input logic [KEY_BITS-1:0] a,
                                        input logic [KEY_BITS-1:0] b,
                                        input logic text,
                                        input logic [3:0] nbytes);
        logic done;
        logic ok;
        logic [3:0] n;
        done = 1'b0;
        ok   = 1'b1;
        n    = (nbytes > 4'd8) ? 4'd8 : nbytes;
        for (int i = 0; i < 8; i++) begin
            if (!done && (4'(i) < n)) begin
                if (a[8*i +: 8] != b[8*i +: 8]) begin
                    ok   = 1'b0;
                    done = 1'b1;
                end else if (text && a[8*i +: 8] == 8'd0) begin
                    done = 1'b1;
                end
            end
        end
        return ok;
    endfunction

endpackage

// File: design/refcounted_key_value_table_core.sv
// Reference-counted key/value table of 64 entries held in a row of cells.
// Each request (add, read data, read count, remove) runs as follows: a
// match token walks the cell row one cell per cycle, picking up the lowest
// matching and the lowest free entry, and the controller then writes the
// chosen entry back. One request is in flight at a time; the result
// register holds until taken. Configuration must be written through
// cfg_we/cfg_index/cfg_data only while idle; the block does not check.
module refcounted_key_value_table_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [3:0]  cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [63:0] s_key,
    input  logic [31:0] s_data_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [31:0] m_data_out,
    output logic [15:0] m_count_out
);
    import rkv_pkg::*;

    logic [1:0]  policy_reg;
    logic        text_reg;
    logic [3:0]  bytes_reg;
    logic [63:0] key;
    logic        scan_en;
    logic        scan_clr;
    wb_t         wb;
    scan_t       chain [ENTRIES+1];

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            policy_reg <= POL_REJECT;
            text_reg   <= 1'b0;
            bytes_reg  <= 4'd8;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_POLICY: policy_reg <= cfg_data[1:0];
                REG_TEXT:   text_reg   <= cfg_data[0];
                REG_BYTES:  bytes_reg  <= cfg_data;
                default:    ;
            endcase
        end
    end

    assign chain[0] = '0;

    for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
        rkv_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .cell_idx    (IDX_BITS'(i)),
            .scan_en     (scan_en),
            .scan_clr    (scan_clr),
            .key         (key),
            .key_is_text (text_reg),
            .key_bytes   (bytes_reg),
            .scan_in     (chain[i]),
            .scan_out    (chain[i+1]),
            .wb          (wb)
        );
    end

    rkv_ctrl u_ctrl (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_mode           (s_mode),
        .s_key            (s_key),
        .s_data_in        (s_data_in),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_data_out       (m_data_out),
        .m_count_out      (m_count_out),
        .duplicate_policy (policy_reg),
        .key              (key),
        .scan_en          (scan_en),
        .scan_clr         (scan_clr),
        .scan_res         (chain[ENTRIES]),
        .wb               (wb)
    );

endmodule

// File: design/rkv_cell.sv
module rkv_cell (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [rkv_pkg::IDX_BITS-1:0] cell_idx,
    input  logic                   scan_en,
    input  logic                   scan_clr,
    input  logic [63:0]            key,
    input  logic                   key_is_text,
    input  logic [3:0]             key_bytes,
    input  rkv_pkg::scan_t         scan_in,
    output rkv_pkg::scan_t         scan_out,
    input  rkv_pkg::wb_t           wb
);
    import rkv_pkg::*;

    logic                  valid_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [DATA_BITS-1:0]  data_reg;
    logic [COUNT_BITS-1:0] count_reg;
    scan_t                 scan_reg;
    scan_t                 scan_next;
    logic                  match;
    logic                  wb_here;

    assign wb_here = wb.en && (wb.idx == cell_idx);

    // Hold entry state; take the write-back aimed at this cell
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (wb_here) begin
            if (wb.set_valid) valid_reg <= 1'b1;
            if (wb.clr_valid) valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (wb_here) begin
            if (wb.wr_key)   key_reg   <= wb.key;
            if (wb.wr_data)  data_reg  <= wb.data;
            if (wb.wr_count) count_reg <= wb.count;
        end
    end

    // Merge this entry into the passing token: first match and first free win
    always_comb begin
        match     = valid_reg && keys_match(key_reg, key, key_is_text, key_bytes);
        scan_next = scan_in;
        if (!scan_in.hit && match) begin
            scan_next.hit       = 1'b1;
            scan_next.hit_idx   = cell_idx;
            scan_next.hit_data  = data_reg;
            scan_next.hit_count = count_reg;
        end
        if (!scan_in.free && !valid_reg) begin
            scan_next.free     = 1'b1;
            scan_next.free_idx = cell_idx;
        end
    end

    // Advance the token one cell per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn || scan_clr) begin
            scan_reg.hit  <= 1'b0;
            scan_reg.free <= 1'b0;
        end else if (scan_en) begin
            scan_reg <= scan_next;
        end
    end

    assign scan_out = scan_reg;

endmodule

// File: design/rkv_ctrl.sv
module rkv_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_mode,
    input  logic [63:0]          s_key,
    input  logic [31:0]          s_data_in,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_status,
    output logic [31:0]          m_data_out,
    output logic [15:0]          m_count_out,
    input  logic [1:0]           duplicate_policy,
    output logic [63:0]          key,
    output logic                 scan_en,
    output logic                 scan_clr,
    input  rkv_pkg::scan_t       scan_res,
    output rkv_pkg::wb_t         wb
);
    import rkv_pkg::*;

    state_t                state_reg, state_next;
    logic [CNT_BITS-1:0]   step_reg, step_next;
    logic [1:0]            mode_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [DATA_BITS-1:0]  data_reg;
    logic [1:0]            status_reg, status_next;
    logic [31:0]           dout_reg, dout_next;
    logic [15:0]           cout_reg, cout_next;
    logic                  finish;

    // Token has left the last cell once the step counter reaches ENTRIES
    assign finish = (state_reg == S_SCAN) && (step_reg == CNT_BITS'(ENTRIES));

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            S_IDLE: begin
                step_next = '0;
                if (s_valid) state_next = S_SCAN;
            end
            S_SCAN: begin
                step_next = step_reg + 1'b1;
                if (finish) state_next = S_DONE;
            end
            S_DONE: begin
                if (m_ready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // Capture the request
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            mode_reg <= s_mode;
            key_reg  <= s_key;
            data_reg <= DATA_BITS'(s_data_in);
        end
    end

    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = (state_reg == S_DONE);
    assign key      = key_reg;
    assign scan_en  = (state_reg == S_SCAN);
    assign scan_clr = (state_reg == S_IDLE);

    // Decide the result and the write-back from the finished token
    always_comb begin
        status_next = ST_OK;
        dout_next   = '0;
        cout_next   = '0;
        wb          = '0;
        wb.key      = key_reg;
        wb.data     = data_reg;
        wb.idx      = scan_res.hit_idx;
        case (mode_reg)
            MODE_ADD: begin
                if (!scan_res.hit) begin
                    if (!scan_res.free) begin
                        status_next = ST_FULL;
                    end else begin
                        wb.en        = 1'b1;
                        wb.idx       = scan_res.free_idx;
                        wb.set_valid = 1'b1;
                        wb.wr_key    = 1'b1;
                        wb.wr_data   = 1'b1;
                        wb.wr_count  = 1'b1;
                        wb.count     = COUNT_BITS'(1);
                    end
                end else if (duplicate_policy == POL_OVERWRITE) begin
                    wb.en      = 1'b1;
                    wb.wr_data = 1'b1;
                end else if (duplicate_policy == POL_INCREMENT) begin
                    wb.en       = 1'b1;
                    wb.wr_count = 1'b1;
                    wb.count    = (scan_res.hit_count == COUNT_MAX) ?
                                  COUNT_MAX : scan_res.hit_count + 1'b1;
                end else begin
                    status_next = ST_DUP;
                end
            end
            MODE_READ: begin
                if (!scan_res.hit) status_next = ST_NOT_FOUND;
                else dout_next = 32'(scan_res.hit_data);
            end
            MODE_COUNT: begin
                if (!scan_res.hit) status_next = ST_NOT_FOUND;
                else cout_next = scan_res.hit_count;
            end
            MODE_REMOVE: begin
                if (!scan_res.hit) begin
                    status_next = ST_NOT_FOUND;
                end else begin
                    wb.en       = 1'b1;
                    wb.wr_count = 1'b1;
                    if (scan_res.hit_count <= COUNT_BITS'(1)) begin
                        wb.count     = '0;
                        wb.clr_valid = 1'b1;
                    end else begin
                        wb.count = scan_res.hit_count - 1'b1;
                    end
                end
            end
            default: status_next = ST_OK;
        endcase
        if (!finish) wb.en = 1'b0;
    end

    // Hold the result until taken
    always_ff @(posedge aclk) begin
        if (finish) begin
            status_reg <= status_next;
            dout_reg   <= dout_next;
            cout_reg   <= cout_next;
        end
    end

    assign m_status    = status_reg;
    assign m_data_out  = dout_reg;
    assign m_count_out = cout_reg;

endmodule

// File: design/rkv_checker.sv
module rkv_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_status,
    input logic [31:0] m_data_out,
    input logic [15:0] m_count_out
);
    import rkv_pkg::*;

    // One request in flight: never ready while a result waits
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("ready while result pending");

    // No result right after acceptance
    a_lat: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !m_valid) else $error("result too early");

    // Stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_status)
        && $stable(m_data_out) && $stable(m_count_out)))
        else $error("result changed while stalled");

    // A failed request carries zero payload
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_OK) |-> (m_data_out == '0 && m_count_out == '0))
        else $error("nonzero payload on failure");

endmodule

bind refcounted_key_value_table_core rkv_checker u_rkv_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_status    (m_status),
    .m_data_out  (m_data_out),
    .m_count_out (m_count_out)
);
